>>> rtl/core/bst_pkg.sv
// bst_pkg: shared types and constants for the binary search tree engine
// no dependencies
`timescale 1ns / 1ps

package bst_pkg;

    localparam int NODES_DEF = 2048;
    localparam int KEY_WORDS = 5;
    localparam int WORD_W    = 64;
    localparam int KEY_W     = KEY_WORDS * WORD_W;
    localparam int INDEX_W   = 11;

    localparam logic [1:0] KIND_SEARCH   = 2'd0;
    localparam logic [1:0] KIND_INSERT   = 2'd1;
    localparam logic [1:0] KIND_DELETE   = 2'd2;
    localparam logic [1:0] KIND_SMALLEST = 2'd3;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    // three-way compare result
    typedef enum logic [1:0] {
        CMP_EQ = 2'd0,
        CMP_LT = 2'd1,
        CMP_GT = 2'd2
    } t_cmp;

endpackage

>>> rtl/core/binary_search_tree_engine.sv
// binary_search_tree_engine: top level, sequencer over node memories and a
// shared key compare; depends on bst_pkg, bst_ram, bst_cmp
`timescale 1ns / 1ps

//  channel  | direction | signals
//  ---------+-----------+---------------------------------------------------
//  in       | input     | i_valid/o_ready, i_kind, i_key_word0..4
//  out      | output    | o_valid/i_ready, o_status, o_node_index, o_out_word0..4
//
// one word at a time; each walk node is a memory read, then a compare; a miss
// adds a read, a fresh insert a free-slot read and a node write (only the read
// on a full pool), a delete a splice decision plus a read and a step per node
// on the successor walk, smallest a read and a step per left-spine node (only
// the read for an empty tree); then the link writes drain, the result shows
// after them and is held until taken, and the next word can be taken in the
// cycle after; after reset a clearing pass writes the free stack, o_ready low

module binary_search_tree_engine #(
    parameter int NODES = bst_pkg::NODES_DEF,
    parameter int AW    = $clog2(NODES),
    parameter int LW    = AW + 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_kind,
    input  logic signed [63:0]         i_key_word0,
    input  logic signed [63:0]         i_key_word1,
    input  logic signed [63:0]         i_key_word2,
    input  logic signed [63:0]         i_key_word3,
    input  logic signed [63:0]         i_key_word4,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [1:0]                 o_status,
    output logic [bst_pkg::INDEX_W-1:0] o_node_index,
    output logic signed [63:0]         o_out_word0,
    output logic signed [63:0]         o_out_word1,
    output logic signed [63:0]         o_out_word2,
    output logic signed [63:0]         o_out_word3,
    output logic signed [63:0]         o_out_word4
);

    localparam logic [LW-1:0] NIL = LW'(NODES);

    typedef enum logic [11:0] {
        S_CLEAR  = 12'b000000000001,
        S_IDLE   = 12'b000000000010,
        S_RD     = 12'b000000000100,  // read node at r_cur
        S_CMP    = 12'b000000001000,  // compare, step
        S_INS    = 12'b000000010000,  // pop free slot read issued
        S_INSW   = 12'b000000100000,  // write new node and parent link
        S_DEL    = 12'b000001000000,  // splice decision
        S_SRD    = 12'b000010000000,  // successor walk read
        S_SSTEP  = 12'b000100000000,  // successor walk step
        S_MRD    = 12'b001000000000,  // smallest walk read
        S_MSTEP  = 12'b010000000000,  // smallest walk step
        S_OUT    = 12'b100000000000
    } t_state;

    t_state r_state, n_state;

    logic [1:0]                r_kind;
    logic [bst_pkg::KEY_W-1:0] r_key;
    logic [LW-1:0]             r_cur, r_par, r_root, r_cnt;
    logic                      r_side;
    logic [LW-1:0]             r_nl, r_nr;    // children of found node
    logic [LW-1:0]             r_s, r_sp;     // successor and its parent
    logic [LW:0]               r_steps;
    logic [AW:0]               r_clr;

    logic [1:0]                r_ostat;
    logic [bst_pkg::INDEX_W-1:0] r_oidx;
    logic [bst_pkg::KEY_W-1:0] r_owords;

    // memory ports
    logic [AW-1:0]             raddr;
    logic [bst_pkg::KEY_W-1:0] key_rd;
    logic [LW-1:0]             l_rd, rt_rd;
    logic [AW-1:0]             fs_rd;
    logic                      key_we, l_we, rt_we, fs_we;
    logic [AW-1:0]             key_wa, l_wa, rt_wa, fs_wa, fs_ra;
    logic [LW-1:0]             l_wd, rt_wd;
    logic [AW-1:0]             fs_wd;
    bst_pkg::t_cmp             cmp;

    // merged write ports
    logic          lwe_f, rwe_f, fwe_f;
    logic [AW-1:0] lwa_f, rwa_f, fwa_f, fwd_f;
    logic [LW-1:0] lwd_f, rwd_f;

    genvar g;
    generate
        for (g = 0; g < bst_pkg::KEY_WORDS; g++) begin : g_key
            bst_ram #(.WIDTH(bst_pkg::WORD_W), .DEPTH(NODES), .AW(AW)) u_key (
                .i_clk  (i_clk),
                .i_we   (key_we),
                .i_waddr(key_wa),
                .i_wdata(r_key[g*bst_pkg::WORD_W +: bst_pkg::WORD_W]),
                .i_raddr(raddr),
                .o_rdata(key_rd[g*bst_pkg::WORD_W +: bst_pkg::WORD_W])
            );
        end
    endgenerate

    bst_ram #(.WIDTH(LW), .DEPTH(NODES), .AW(AW)) u_left (
        .i_clk(i_clk), .i_we(lwe_f), .i_waddr(lwa_f), .i_wdata(lwd_f),
        .i_raddr(raddr), .o_rdata(l_rd)
    );
    bst_ram #(.WIDTH(LW), .DEPTH(NODES), .AW(AW)) u_right (
        .i_clk(i_clk), .i_we(rwe_f), .i_waddr(rwa_f), .i_wdata(rwd_f),
        .i_raddr(raddr), .o_rdata(rt_rd)
    );
    bst_ram #(.WIDTH(AW), .DEPTH(NODES), .AW(AW)) u_free (
        .i_clk(i_clk), .i_we(fwe_f), .i_waddr(fwa_f), .i_wdata(fwd_f),
        .i_raddr(fs_ra), .o_rdata(fs_rd)
    );

    bst_cmp u_cmp (.i_stored(key_rd), .i_key(r_key), .o_res(cmp));

    // key words are stored word 0 in the top slice so concatenation is
    // lexicographic: word0 sits at bits [KEY_W-1 -: 64]
    logic [bst_pkg::KEY_W-1:0] in_key;
    assign in_key = {i_key_word0, i_key_word1, i_key_word2, i_key_word3, i_key_word4};

    logic walk_end, succ_two;
    assign walk_end = (r_steps == (LW+1)'(NODES));
    assign succ_two = (r_nl != NIL) && (r_nr != NIL);

    // deferred link writes (up to 4), drained one per cycle in S_OUT before
    // valid is shown: parent link, sp.left, s.right, s.left
    logic          r_shown;
    logic [3:0]    r_wv;
    logic [3:0]    r_wleft;
    logic [AW-1:0] r_wa_q [4];
    logic [LW-1:0] r_wd_q [4];
    logic [1:0]    r_wi;

    // combinational control
    always_comb begin
        n_state = r_state;
        raddr   = r_cur[AW-1:0];
        key_we  = 1'b0; key_wa = fs_rd;
        l_we    = 1'b0; l_wa = r_cur[AW-1:0]; l_wd = NIL;
        rt_we   = 1'b0; rt_wa = r_cur[AW-1:0]; rt_wd = NIL;
        fs_we   = 1'b0; fs_wa = r_clr[AW-1:0]; fs_wd = AW'(NODES - 1) - r_clr[AW-1:0];
        fs_ra   = AW'(r_cnt - 1'b1);
        case (r_state)
            S_CLEAR: begin
                fs_we = 1'b1;
                if (r_clr == (AW+1)'(NODES - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_state = (i_kind == bst_pkg::KIND_SMALLEST) ? S_MRD : S_RD;
                end
            end
            S_RD: begin
                if (r_cur == NIL || walk_end) begin
                    if (r_kind == bst_pkg::KIND_INSERT) n_state = S_INS;
                    else n_state = S_OUT;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (cmp == bst_pkg::CMP_EQ) begin
                    n_state = (r_kind == bst_pkg::KIND_DELETE) ? S_DEL : S_OUT;
                end else begin
                    n_state = S_RD;
                end
            end
            S_INS: begin
                n_state = (r_cnt == '0) ? S_OUT : S_INSW;
            end
            S_INSW: begin
                key_we = 1'b1; key_wa = fs_rd;
                l_we = 1'b1; l_wa = fs_rd; l_wd = NIL;
                rt_we = 1'b1; rt_wa = fs_rd; rt_wd = NIL;
                n_state = S_OUT;
            end
            S_DEL: begin
                raddr = r_nr[AW-1:0];
                n_state = succ_two ? S_SRD : S_OUT;
            end
            S_SRD: begin
                raddr = r_s[AW-1:0];
                n_state = S_SSTEP;
            end
            S_SSTEP: begin
                raddr = r_s[AW-1:0];
                if (l_rd == NIL || walk_end) n_state = S_OUT;
                else n_state = S_SRD;
            end
            S_MRD: begin
                raddr = r_cur[AW-1:0];
                n_state = (r_cur == NIL) ? S_OUT : S_MSTEP;
            end
            S_MSTEP: begin
                raddr = r_cur[AW-1:0];
                if (l_rd == NIL || walk_end) n_state = S_OUT;
                else n_state = S_MRD;
            end
            S_OUT: begin
                if (r_shown && i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_cnt   <= LW'(NODES);
            r_root  <= NIL;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_CLEAR: r_clr <= r_clr + 1'b1;
                S_IDLE: begin
                    if (i_valid) begin
                        r_kind  <= i_kind;
                        r_key   <= in_key;
                        r_cur   <= r_root;
                        r_par   <= NIL;
                        r_side  <= 1'b0;
                        r_steps <= '0;
                        r_ostat <= bst_pkg::ST_NOTFOUND;
                        r_oidx  <= '0;
                        r_owords <= '0;
                    end
                end
                S_CMP: begin
                    if (cmp == bst_pkg::CMP_EQ) begin
                        r_ostat <= bst_pkg::ST_DONE;
                        r_oidx  <= bst_pkg::INDEX_W'(r_cur);
                        r_nl    <= l_rd;
                        r_nr    <= rt_rd;
                        r_s     <= rt_rd;
                        r_sp    <= NIL;
                        r_steps <= '0;
                    end else begin
                        r_par   <= r_cur;
                        r_side  <= (cmp == bst_pkg::CMP_LT);
                        r_cur   <= (cmp == bst_pkg::CMP_LT) ? rt_rd : l_rd;
                        r_steps <= r_steps + 1'b1;
                    end
                end
                S_INS: begin
                    if (r_cnt == '0) r_ostat <= bst_pkg::ST_FULL;
                end
                S_INSW: begin
                    r_cnt   <= r_cnt - 1'b1;
                    r_ostat <= bst_pkg::ST_DONE;
                    r_oidx  <= bst_pkg::INDEX_W'(fs_rd);
                    if (r_par == NIL) r_root <= LW'(fs_rd);
                end
                S_DEL: begin
                    if (!succ_two) begin
                        if (r_par == NIL) r_root <= (r_nl == NIL) ? r_nr : r_nl;
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_SSTEP: begin
                    if (l_rd == NIL || walk_end) begin
                        if (r_par == NIL) r_root <= r_s;
                        r_cnt <= r_cnt + 1'b1;
                    end else begin
                        r_sp    <= r_s;
                        r_s     <= l_rd;
                        r_steps <= r_steps + 1'b1;
                    end
                end
                S_MSTEP: begin
                    if (l_rd == NIL || walk_end) begin
                        r_ostat  <= bst_pkg::ST_DONE;
                        r_oidx   <= bst_pkg::INDEX_W'(r_cur);
                        r_owords <= key_rd;
                    end else begin
                        r_cur   <= l_rd;
                        r_steps <= r_steps + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    logic do_w;
    assign do_w = (r_state == S_OUT) && r_wv[r_wi];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wv    <= '0;
            r_wi    <= '0;
            r_shown <= 1'b0;
        end else begin
            if (r_state == S_IDLE) begin
                r_wv <= '0; r_wi <= '0; r_shown <= 1'b0;
            end
            if (r_state == S_INSW && r_par != NIL) begin
                r_wv[0] <= 1'b1; r_wleft[0] <= !r_side;
                r_wa_q[0] <= r_par[AW-1:0]; r_wd_q[0] <= LW'(fs_rd);
            end
            if (r_state == S_DEL && !succ_two && r_par != NIL) begin
                r_wv[0] <= 1'b1; r_wleft[0] <= !r_side;
                r_wa_q[0] <= r_par[AW-1:0]; r_wd_q[0] <= (r_nl == NIL) ? r_nr : r_nl;
            end
            if (r_state == S_SSTEP && (l_rd == NIL || walk_end)) begin
                r_wv[0] <= (r_par != NIL); r_wleft[0] <= !r_side;
                r_wa_q[0] <= r_par[AW-1:0]; r_wd_q[0] <= r_s;
                r_wv[1] <= (r_sp != NIL); r_wleft[1] <= 1'b1;
                r_wa_q[1] <= r_sp[AW-1:0]; r_wd_q[1] <= rt_rd;
                r_wv[2] <= (r_sp != NIL); r_wleft[2] <= 1'b0;
                r_wa_q[2] <= r_s[AW-1:0]; r_wd_q[2] <= r_nr;
                r_wv[3] <= 1'b1; r_wleft[3] <= 1'b1;
                r_wa_q[3] <= r_s[AW-1:0]; r_wd_q[3] <= r_nl;
            end
            if (r_state == S_OUT && !r_shown) begin
                if (r_wi == 2'd3) r_shown <= 1'b1;
                r_wi <= r_wi + 1'b1;
                r_wv[r_wi] <= 1'b0;
            end
        end
    end

    // free stack push on delete is written at the splice, ahead of the link writes
    logic push_we;
    assign push_we = ((r_state == S_DEL && !succ_two)
                   || (r_state == S_SSTEP && (l_rd == NIL || walk_end)))
                   && (r_cnt != LW'(NODES));

    // merge deferred writes onto memory ports
    logic          m_lwe, m_rwe;
    always_comb begin
        m_lwe = do_w && r_wleft[r_wi];
        m_rwe = do_w && !r_wleft[r_wi];
    end

    // deferred writes only occur in S_OUT, where the sequencer drives no writes
    always_comb begin
        lwe_f = l_we | m_lwe;
        lwa_f = m_lwe ? r_wa_q[r_wi] : l_wa;
        lwd_f = m_lwe ? r_wd_q[r_wi] : l_wd;
        rwe_f = rt_we | m_rwe;
        rwa_f = m_rwe ? r_wa_q[r_wi] : rt_wa;
        rwd_f = m_rwe ? r_wd_q[r_wi] : rt_wd;
        fwe_f = fs_we | push_we;
        fwa_f = push_we ? r_cnt[AW-1:0] : fs_wa;
        fwd_f = push_we ? r_oidx[AW-1:0] : fs_wd;
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = (r_state == S_OUT) && r_shown;
    assign o_status     = r_ostat;
    assign o_node_index = r_oidx;
    assign o_out_word0  = r_owords[4*64 +: 64];
    assign o_out_word1  = r_owords[3*64 +: 64];
    assign o_out_word2  = r_owords[2*64 +: 64];
    assign o_out_word3  = r_owords[1*64 +: 64];
    assign o_out_word4  = r_owords[0*64 +: 64];

endmodule

>>> rtl/core/bst_ram.sv
// bst_ram: generic single-port write, single-port registered-read memory
// no dependencies
`timescale 1ns / 1ps

module bst_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/bst_cmp.sv
// bst_cmp: shared lexicographic compare unit, signed 64-bit words
// depends on bst_pkg
`timescale 1ns / 1ps

module bst_cmp (
    input  logic [bst_pkg::KEY_W-1:0] i_stored,
    input  logic [bst_pkg::KEY_W-1:0] i_key,
    output bst_pkg::t_cmp             o_res
);

    // flipping every word's sign bit turns signed order into unsigned order,
    // and concatenated words then compare lexicographically
    logic [bst_pkg::KEY_W-1:0] a;
    logic [bst_pkg::KEY_W-1:0] b;

    always_comb begin
        a = i_stored;
        b = i_key;
        for (int w = 0; w < bst_pkg::KEY_WORDS; w++) begin
            a[w*bst_pkg::WORD_W + bst_pkg::WORD_W-1] = ~i_stored[w*bst_pkg::WORD_W + bst_pkg::WORD_W-1];
            b[w*bst_pkg::WORD_W + bst_pkg::WORD_W-1] = ~i_key[w*bst_pkg::WORD_W + bst_pkg::WORD_W-1];
        end
        if (a == b) begin
            o_res = bst_pkg::CMP_EQ;
        end else if (a < b) begin
            o_res = bst_pkg::CMP_LT;
        end else begin
            o_res = bst_pkg::CMP_GT;
        end
    end

endmodule

>>> test/binary_search_tree_engine_tb.sv
// binary_search_tree_engine_tb: self-checking testbench for the tree engine,
// with a scoreboard class that mirrors the tree; depends on bst_pkg and the rtl
`timescale 1ns / 1ps

module binary_search_tree_engine_tb;

    localparam int NODES      = bst_pkg::NODES_DEF;
    localparam int NIL        = NODES;
    localparam int CYCLE_CAP  = 10_000_000;
    localparam int HOLD_LEN   = 400;
    localparam int FILL_LEN   = 500;

    typedef logic [bst_pkg::KEY_WORDS-1:0][bst_pkg::WORD_W-1:0] t_key;

    typedef struct packed {
        logic [1:0]                  status;
        logic [bst_pkg::INDEX_W-1:0] index;
        t_key                        words;
    } t_reply;

    // mirror of the node pool, free stack and root, plus the replies still owed
    class tree_scoreboard;
        t_key        node_key[NODES];
        int unsigned left_of[NODES];
        int unsigned right_of[NODES];
        int unsigned free_stack[NODES];
        int unsigned free_cnt;
        int unsigned root;
        t_reply      owed[$];
        int          errors;

        function new();
            for (int i = 0; i < NODES; i++) begin
                node_key[i]   = '0;
                left_of[i]    = NIL;
                right_of[i]   = NIL;
                free_stack[i] = NODES - 1 - i;
            end
            free_cnt = NODES;
            root     = NIL;
            errors   = 0;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // +1 when stored key is larger, -1 when smaller
        function int order_of(int unsigned n, t_key k);
            for (int w = 0; w < bst_pkg::KEY_WORDS; w++) begin
                if ($signed(node_key[n][w]) > $signed(k[w])) return 1;
                if ($signed(node_key[n][w]) < $signed(k[w])) return -1;
            end
            return 0;
        endfunction

        function bit locate(t_key k, output int unsigned node, output int unsigned parent,
                            output bit right_side);
            int unsigned n;
            int          r;
            n = root;
            parent = NIL;
            right_side = 0;
            node = NIL;
            while (n != NIL) begin
                r = order_of(n, k);
                node = n;
                if (r == 0) return 1;
                parent = n;
                if (r < 0) begin
                    right_side = 1;
                    n = right_of[n];
                end else begin
                    right_side = 0;
                    n = left_of[n];
                end
            end
            return 0;
        endfunction

        function void note_word(logic [1:0] kind, t_key k);
            t_reply      exp;
            int unsigned node, parent, cl, cr, repl, s, sp, j, n;
            bit          side;
            exp = '{status: bst_pkg::ST_NOTFOUND, index: '0, words: '0};
            case (kind)
                bst_pkg::KIND_SEARCH: begin
                    if (locate(k, node, parent, side)) begin
                        exp.status = bst_pkg::ST_DONE;
                        exp.index  = bst_pkg::INDEX_W'(node);
                    end
                end
                bst_pkg::KIND_INSERT: begin
                    if (locate(k, node, parent, side)) begin
                        exp.status = bst_pkg::ST_DONE;
                        exp.index  = bst_pkg::INDEX_W'(node);
                    end else if (free_cnt == 0) begin
                        exp.status = bst_pkg::ST_FULL;
                    end else begin
                        free_cnt--;
                        j = free_stack[free_cnt];
                        node_key[j] = k;
                        left_of[j]  = NIL;
                        right_of[j] = NIL;
                        // hang the new node off the last node visited
                        if (node == NIL) root = j;
                        else if (side) right_of[node] = j;
                        else left_of[node] = j;
                        exp.status = bst_pkg::ST_DONE;
                        exp.index  = bst_pkg::INDEX_W'(j);
                    end
                end
                bst_pkg::KIND_DELETE: begin
                    if (locate(k, node, parent, side)) begin
                        cl = left_of[node];
                        cr = right_of[node];
                        if (cl == NIL) repl = cr;
                        else if (cr == NIL) repl = cl;
                        else begin
                            // in-order successor: leftmost node of right subtree
                            s  = cr;
                            sp = NIL;
                            while (left_of[s] != NIL) begin
                                sp = s;
                                s  = left_of[s];
                            end
                            if (sp != NIL) begin
                                left_of[sp] = right_of[s];
                                right_of[s] = cr;
                            end
                            left_of[s] = cl;
                            repl = s;
                        end
                        if (parent == NIL) root = repl;
                        else if (side) right_of[parent] = repl;
                        else left_of[parent] = repl;
                        if (free_cnt < NODES) begin
                            free_stack[free_cnt] = node;
                            free_cnt++;
                        end
                        exp.status = bst_pkg::ST_DONE;
                        exp.index  = bst_pkg::INDEX_W'(node);
                    end
                end
                default: begin
                    n = root;
                    if (n != NIL) begin
                        while (left_of[n] != NIL) n = left_of[n];
                        exp.status = bst_pkg::ST_DONE;
                        exp.index  = bst_pkg::INDEX_W'(n);
                        exp.words  = node_key[n];
                    end
                end
            endcase
            owed.push_back(exp);
        endfunction

        task check_word(t_reply got);
            t_reply exp;
            if (owed.size() == 0) begin
                report($sformatf("unexpected word status %0d index %0d", got.status, got.index));
                return;
            end
            exp = owed.pop_front();
            if (got.status !== exp.status)
                report($sformatf("status %0d, want %0d", got.status, exp.status));
            if (got.index !== exp.index)
                report($sformatf("node index %0d, want %0d", got.index, exp.index));
            for (int w = 0; w < bst_pkg::KEY_WORDS; w++)
                if (got.words[w] !== exp.words[w])
                    report($sformatf("out word %0d %h, want %h", w, got.words[w],
                                     exp.words[w]));
        endtask
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_ready;
    logic [1:0]                  i_kind = bst_pkg::KIND_SEARCH;
    logic signed [63:0]          i_key_word0 = '0;
    logic signed [63:0]          i_key_word1 = '0;
    logic signed [63:0]          i_key_word2 = '0;
    logic signed [63:0]          i_key_word3 = '0;
    logic signed [63:0]          i_key_word4 = '0;
    logic                        o_valid;
    logic                        i_ready = 1'b0;
    logic [1:0]                  o_status;
    logic [bst_pkg::INDEX_W-1:0] o_node_index;
    logic signed [63:0]          o_out_word0;
    logic signed [63:0]          o_out_word1;
    logic signed [63:0]          o_out_word2;
    logic signed [63:0]          o_out_word3;
    logic signed [63:0]          o_out_word4;

    tree_scoreboard sb = new();
    int             gap_pct = 0;      // chance per cycle that the sender idles
    int             stall_pct = 0;    // chance per cycle that the receiver stalls
    int             hold_left = 0;    // long receiver hold-off, counted down below
    int             cycle_cnt = 0;
    t_key           key_pool[48];
    t_key           fill_keys[$];

    binary_search_tree_engine i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_key_word0  (i_key_word0),
        .i_key_word1  (i_key_word1),
        .i_key_word2  (i_key_word2),
        .i_key_word3  (i_key_word3),
        .i_key_word4  (i_key_word4),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_node_index (o_node_index),
        .o_out_word0  (o_out_word0),
        .o_out_word1  (o_out_word1),
        .o_out_word2  (o_out_word2),
        .o_out_word3  (o_out_word3),
        .o_out_word4  (o_out_word4)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // output monitor and run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("binary_search_tree_engine_tb failed");
            $finish;
        end
        if (i_rst_n && o_valid && i_ready)
            sb.check_word('{status: o_status, index: o_node_index,
                            words: {o_out_word4, o_out_word3, o_out_word2,
                                    o_out_word1, o_out_word0}});
    end

    // word values biased toward the signed extremes and shared prefixes
    function automatic t_key make_key();
        t_key k;
        for (int w = 0; w < bst_pkg::KEY_WORDS; w++) begin
            case ($urandom_range(0, 5))
                0:       k[w] = 64'h8000_0000_0000_0000;
                1:       k[w] = 64'h7fff_ffff_ffff_ffff;
                2:       k[w] = '0;
                3:       k[w] = '1;
                4:       k[w] = 64'($urandom_range(0, 3));
                default: k[w] = {$urandom, $urandom};
            endcase
        end
        return k;
    endfunction

    function automatic t_key fresh_key();
        t_key k;
        for (int w = 0; w < bst_pkg::KEY_WORDS; w++) k[w] = {$urandom, $urandom};
        return k;
    endfunction

    // offer one word and hold it until taken, then idle at random
    task automatic send_word(logic [1:0] kind, t_key k);
        i_valid     <= 1'b1;
        i_kind      <= kind;
        i_key_word0 <= k[0];
        i_key_word1 <= k[1];
        i_key_word2 <= k[2];
        i_key_word3 <= k[3];
        i_key_word4 <= k[4];
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_word(kind, k);
        while ($urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic random_mix(int count);
        int   pick;
        t_key k;
        for (int i = 0; i < count; i++) begin
            k = ($urandom_range(0, 4) == 0) ? make_key()
                                            : key_pool[$urandom_range(0, 47)];
            pick = $urandom_range(0, 99);
            if (pick < 40)      send_word(bst_pkg::KIND_INSERT, k);
            else if (pick < 60) send_word(bst_pkg::KIND_DELETE, k);
            else if (pick < 85) send_word(bst_pkg::KIND_SEARCH, k);
            else                send_word(bst_pkg::KIND_SMALLEST, fresh_key());
        end
    endtask

    initial begin
        t_key lo_key, hi_key, zero_key, plus_key, minus_key, odd_key;
        t_key k;
        int   pick;

        lo_key    = {bst_pkg::KEY_WORDS{64'h8000_0000_0000_0000}};
        hi_key    = {bst_pkg::KEY_WORDS{64'h7fff_ffff_ffff_ffff}};
        zero_key  = '0;
        plus_key  = '0;
        plus_key[4] = 64'd1;
        minus_key = '0;
        minus_key[4] = '1;
        odd_key   = fresh_key();
        odd_key[0] = '1;
        for (int i = 0; i < 48; i++) key_pool[i] = make_key();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty tree, extremes, duplicate, all delete shapes
        send_word(bst_pkg::KIND_SMALLEST, hi_key);
        send_word(bst_pkg::KIND_SEARCH, zero_key);
        send_word(bst_pkg::KIND_DELETE, zero_key);
        send_word(bst_pkg::KIND_INSERT, zero_key);
        send_word(bst_pkg::KIND_INSERT, lo_key);
        send_word(bst_pkg::KIND_INSERT, hi_key);
        send_word(bst_pkg::KIND_INSERT, plus_key);
        send_word(bst_pkg::KIND_INSERT, minus_key);
        send_word(bst_pkg::KIND_INSERT, zero_key);       // already present
        send_word(bst_pkg::KIND_SEARCH, plus_key);
        send_word(bst_pkg::KIND_SEARCH, odd_key);        // missing
        send_word(bst_pkg::KIND_SMALLEST, zero_key);
        send_word(bst_pkg::KIND_INSERT, odd_key);
        send_word(bst_pkg::KIND_DELETE, zero_key);       // two children
        send_word(bst_pkg::KIND_DELETE, lo_key);         // one child
        send_word(bst_pkg::KIND_DELETE, hi_key);
        send_word(bst_pkg::KIND_SMALLEST, zero_key);
        send_word(bst_pkg::KIND_DELETE, plus_key);
        send_word(bst_pkg::KIND_DELETE, minus_key);
        send_word(bst_pkg::KIND_DELETE, odd_key);
        send_word(bst_pkg::KIND_SMALLEST, zero_key);     // empty again
        send_word(bst_pkg::KIND_SEARCH, hi_key);
        drain();

        // random mix over a small key pool, one idling pattern per phase
        random_mix(200);
        drain();
        gap_pct = 85;
        random_mix(200);
        drain();                                // sender pauses until all words are back
        gap_pct   = 0;
        stall_pct = 85;
        hold_left = HOLD_LEN;                   // receiver holds off while words keep coming
        random_mix(200);
        drain();
        gap_pct   = 34;
        stall_pct = 34;
        random_mix(200);
        drain();

        // grow a deep tree of random keys
        gap_pct   = 0;
        stall_pct = 0;
        for (int i = 0; i < FILL_LEN; i++) begin
            k = fresh_key();
            fill_keys.push_back(k);
            send_word(bst_pkg::KIND_INSERT, k);
        end
        send_word(bst_pkg::KIND_INSERT, fill_keys[5]);   // duplicate
        drain();

        // work on the crowded tree
        gap_pct   = 34;
        stall_pct = 34;
        for (int i = 0; i < 127; i++) begin
            k = fill_keys[$urandom_range(0, fill_keys.size() - 1)];
            pick = $urandom_range(0, 99);
            if (pick < 45)      send_word(bst_pkg::KIND_DELETE, k);
            else if (pick < 70) send_word(bst_pkg::KIND_SEARCH, k);
            else if (pick < 90) send_word(bst_pkg::KIND_INSERT,
                                          ($urandom_range(0, 1) != 0) ? k : fresh_key());
            else                send_word(bst_pkg::KIND_SMALLEST, k);
        end
        drain();

        repeat (300) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("binary_search_tree_engine_tb passed");
        end else begin
            $display("binary_search_tree_engine_tb failed");
        end
        $finish;
    end

endmodule
